### rtl/ptw_pkg.sv
// Package with the word types, codes and sizes of the three-level page table walker.
`timescale 1ns / 1ps

package ptw_pkg;

    // Default number of quadwords in the table store.
    localparam int TABLE_WORDS_DEF = 4096;

    // Widths fixed by the field and register definitions.
    localparam int VA_W      = 64;
    localparam int WIDX_W    = 12;
    localparam int DATA_W    = 64;
    localparam int FRAME_W   = 32;
    localparam int PBASE_W   = 48;
    localparam int PSHIFT_W  = 5;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    // Widest index field (page shift 16) and widest word address (32-bit frame on top).
    localparam int IDX_W     = 13;
    localparam int WADDR_W   = FRAME_W + IDX_W;

    // Page shift limits.
    localparam logic [PSHIFT_W-1:0] PSHIFT_MIN = 5'd13;
    localparam logic [PSHIFT_W-1:0] PSHIFT_MAX = 5'd16;

    // Register reset values.
    localparam logic [PSHIFT_W-1:0] PSHIFT_RST = 5'd13;
    localparam logic [FRAME_W-1:0]  BASE_RST   = 32'd0;
    localparam logic [CFG_W-1:0]    VMASK_RST  = 32'd1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MASK = 2'd2;

    // Operation codes.
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_WRITE     = 1'b1;

    typedef struct packed {
        logic              op;
        logic [VA_W-1:0]   virt_addr;
        logic [WIDX_W-1:0] word_index;
        logic [DATA_W-1:0] word_data;
    } req_t;

    typedef struct packed {
        logic [PBASE_W-1:0] phys_page_base;
        logic               fault;
    } rsp_t;

endpackage

### rtl/three_level_page_table_walk.sv
// Three-level page table walker over an internal quadword table store.
// A translate word is walked through states LVL1, LVL2 and LVL3 by three dependent reads of the
// table store and gives its result from LVL3, or from LVL1 or LVL2 when the first or second level
// faults, once the result register is free; new words stall until the walker is back in IDLE.
// A table write is done on acceptance. After reset the store is cleared, one word a cycle, before
// the first word is accepted; the registers take their reset values at once.
`timescale 1ns / 1ps

module three_level_page_table_walk #(
    parameter int TABLE_WORDS = ptw_pkg::TABLE_WORDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ptw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptw_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  ptw_pkg::req_t                   req_word,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output ptw_pkg::rsp_t                   rsp_word
);

    localparam int AW = $clog2(TABLE_WORDS);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_LVL1  = 5'b00100,
        ST_LVL2  = 5'b01000,
        ST_LVL3  = 5'b10000
    } state_t;

    // Index field of one level; k selects the page shift (13 + k).
    function automatic logic [ptw_pkg::IDX_W-1:0] va_index(
        input logic [ptw_pkg::VA_W-1:0] va,
        input logic [1:0]               k,
        input logic [1:0]               lvl
    );
        logic [ptw_pkg::IDX_W-1:0] idx;
        idx = '0;
        case ({k, lvl})
            4'b00_00: idx = ptw_pkg::IDX_W'(va[42:33]);
            4'b00_01: idx = ptw_pkg::IDX_W'(va[32:23]);
            4'b00_10: idx = ptw_pkg::IDX_W'(va[22:13]);
            4'b01_00: idx = ptw_pkg::IDX_W'(va[46:36]);
            4'b01_01: idx = ptw_pkg::IDX_W'(va[35:25]);
            4'b01_10: idx = ptw_pkg::IDX_W'(va[24:14]);
            4'b10_00: idx = ptw_pkg::IDX_W'(va[50:39]);
            4'b10_01: idx = ptw_pkg::IDX_W'(va[38:27]);
            4'b10_10: idx = ptw_pkg::IDX_W'(va[26:15]);
            4'b11_00: idx = va[54:42];
            4'b11_01: idx = va[41:29];
            4'b11_10: idx = va[28:16];
            default:  idx = '0;
        endcase
        return idx;
    endfunction

    // Quadword address of an entry: the frame sits directly above the index field.
    function automatic logic [ptw_pkg::WADDR_W-1:0] entry_addr(
        input logic [ptw_pkg::FRAME_W-1:0] frame,
        input logic [ptw_pkg::IDX_W-1:0]   idx,
        input logic [1:0]                  k
    );
        logic [ptw_pkg::WADDR_W-1:0] addr;
        addr = '0;
        case (k)
            2'd0:    addr = ptw_pkg::WADDR_W'({frame, idx[9:0]});
            2'd1:    addr = ptw_pkg::WADDR_W'({frame, idx[10:0]});
            2'd2:    addr = ptw_pkg::WADDR_W'({frame, idx[11:0]});
            default: addr = {frame, idx};
        endcase
        return addr;
    endfunction

    function automatic logic [ptw_pkg::PBASE_W-1:0] page_base(
        input logic [ptw_pkg::FRAME_W-1:0] frame,
        input logic [1:0]                  k
    );
        logic [ptw_pkg::PBASE_W-1:0] base;
        base = '0;
        case (k)
            2'd0:    base = ptw_pkg::PBASE_W'({frame, 13'd0});
            2'd1:    base = ptw_pkg::PBASE_W'({frame, 14'd0});
            2'd2:    base = ptw_pkg::PBASE_W'({frame, 15'd0});
            default: base = {frame, 16'd0};
        endcase
        return base;
    endfunction

    logic [ptw_pkg::DATA_W-1:0]   table_mem [TABLE_WORDS];

    state_t                       state_reg, state_next;
    logic [AW-1:0]                clr_cnt_reg, clr_cnt_next;
    logic [ptw_pkg::PSHIFT_W-1:0] page_shift_reg;
    logic [ptw_pkg::FRAME_W-1:0]  base_frame_reg;
    logic [ptw_pkg::CFG_W-1:0]    valid_mask_reg;
    logic [ptw_pkg::VA_W-1:0]     va_reg, va_next;
    logic [ptw_pkg::DATA_W-1:0]   mem_rd_reg;
    logic                         rd_ok_reg, rd_ok_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    ptw_pkg::rsp_t                rsp_reg, rsp_next;

    logic                         mem_we, mem_re;
    logic [AW-1:0]                mem_waddr, mem_raddr;
    logic [ptw_pkg::DATA_W-1:0]   mem_wdata;

    logic [1:0]                   shift_k;
    logic                         req_accept, rsp_free;
    logic [31:0]                  wi_wide;
    logic [ptw_pkg::DATA_W-1:0]   entry;
    logic                         entry_ok;
    logic [ptw_pkg::FRAME_W-1:0]  next_frame, walk_frame;
    logic [1:0]                   walk_lvl;
    logic [ptw_pkg::VA_W-1:0]     walk_va;
    logic [ptw_pkg::WADDR_W-1:0]  walk_addr;
    logic                         walk_in_range;

    // Page shifts outside 13..16 act as the nearest limit.
    always_comb
    begin
        if (page_shift_reg < ptw_pkg::PSHIFT_MIN)
            shift_k = 2'd0;
        else if (page_shift_reg > ptw_pkg::PSHIFT_MAX)
            shift_k = 2'd3;
        else
            shift_k = 2'(page_shift_reg - ptw_pkg::PSHIFT_MIN);
    end

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign wi_wide    = 32'(req_word.word_index);

    // An entry read from beyond the store counts as zero.
    assign entry      = rd_ok_reg ? mem_rd_reg : '0;
    assign entry_ok   = ((entry[ptw_pkg::CFG_W-1:0] & valid_mask_reg) == valid_mask_reg);
    assign next_frame = entry[ptw_pkg::DATA_W-1:ptw_pkg::FRAME_W];

    // Address of the next read: from the base frame on accept, else from the entry just read.
    always_comb
    begin
        walk_frame = next_frame;
        walk_va    = va_reg;
        walk_lvl   = 2'd2;
        if (state_reg == ST_IDLE)
        begin
            walk_frame = base_frame_reg;
            walk_va    = req_word.virt_addr;
            walk_lvl   = 2'd0;
        end
        else if (state_reg == ST_LVL1)
        begin
            walk_lvl = 2'd1;
        end
        walk_addr     = entry_addr(walk_frame, va_index(walk_va, shift_k, walk_lvl), shift_k);
        walk_in_range = (walk_addr < ptw_pkg::WADDR_W'(TABLE_WORDS));
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        va_next        = va_reg;
        rd_ok_next     = rd_ok_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_waddr      = clr_cnt_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = walk_addr[AW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(TABLE_WORDS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (req_word.op == ptw_pkg::OP_WRITE)
                    begin
                        mem_we    = (wi_wide < 32'(TABLE_WORDS));
                        mem_waddr = wi_wide[AW-1:0];
                        mem_wdata = req_word.word_data;
                    end
                    else
                    begin
                        mem_re     = walk_in_range;
                        rd_ok_next = walk_in_range;
                        va_next    = req_word.virt_addr;
                        state_next = ST_LVL1;
                    end
                end
            end
            ST_LVL1, ST_LVL2:
            begin
                // A fault waits here for the result register; the read data holds meanwhile.
                if (!entry_ok)
                begin
                    if (rsp_free)
                    begin
                        rsp_next.phys_page_base = '0;
                        rsp_next.fault          = 1'b1;
                        rsp_valid_next          = 1'b1;
                        state_next              = ST_IDLE;
                    end
                end
                else
                begin
                    mem_re     = walk_in_range;
                    rd_ok_next = walk_in_range;
                    state_next = (state_reg == ST_LVL1) ? ST_LVL2 : ST_LVL3;
                end
            end
            ST_LVL3:
            begin
                if (rsp_free)
                begin
                    rsp_next.phys_page_base = entry_ok ? page_base(next_frame, shift_k) : '0;
                    rsp_next.fault          = !entry_ok;
                    rsp_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            mem_rd_reg <= table_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        va_reg    <= va_next;
        rd_ok_reg <= rd_ok_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg <= ptw_pkg::PSHIFT_RST;
            base_frame_reg <= ptw_pkg::BASE_RST;
            valid_mask_reg <= ptw_pkg::VMASK_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ptw_pkg::CFG_PAGE_SHIFT: page_shift_reg <= cfg_data[ptw_pkg::PSHIFT_W-1:0];
                ptw_pkg::CFG_BASE_FRAME: base_frame_reg <= cfg_data;
                ptw_pkg::CFG_VALID_MASK: valid_mask_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

endmodule
